/* rtl/core/itp_pkg.sv */
// shared types, constants and helpers of the infix to postfix converter
`default_nettype none
package itp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam logic [7:0] CHAR_ADD = 8'h2B;
    localparam logic [7:0] CHAR_SUB = 8'h2D;
    localparam logic [7:0] CHAR_MUL = 8'h2A;
    localparam logic [7:0] CHAR_DIV = 8'h2F;

    // stacked operator codes, msb set means high precedence
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_opc;

    typedef struct packed {
        logic is_op;
        t_opc code;
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_WORK  = 2'd1,
        S_FLUSH = 2'd2
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic emit_sym;
        logic pop_emit;
        logic push;
        logic set_ovf;
        logic last;
        logic clear_ovf;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_op;
        logic is_end;
        logic top_ge;
        logic empty;
        logic full;
        logic count_one;
        logic out_free;
    } t_stat;

    function automatic t_op classify(input logic [7:0] c);
        t_op r;
        r.is_op = 1'b1;
        case (c)
            CHAR_ADD: r.code = OP_ADD;
            CHAR_SUB: r.code = OP_SUB;
            CHAR_MUL: r.code = OP_MUL;
            CHAR_DIV: r.code = OP_DIV;
            default: begin
                r.is_op = 1'b0;
                r.code  = OP_ADD;
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] op_char(input t_opc code);
        logic [7:0] r;
        case (code)
            OP_ADD:  r = CHAR_ADD;
            OP_SUB:  r = CHAR_SUB;
            OP_MUL:  r = CHAR_MUL;
            OP_DIV:  r = CHAR_DIV;
            default: r = CHAR_ADD;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/itp_channels.sv */
// valid/ready channel interfaces for expression characters and postfix results
`default_nettype none
interface itp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       end_of_expression;

    modport source (output valid, output symbol, output end_of_expression, input ready);
    modport sink   (input valid, input symbol, input end_of_expression, output ready);
endinterface

interface itp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_symbol;
    logic       last;
    logic       overflow;

    modport source (output valid, output out_symbol, output last, output overflow, input ready);
    modport sink   (input valid, input out_symbol, input last, input overflow, output ready);
endinterface
`default_nettype wire

/* rtl/core/infix_to_postfix_converter.sv */
// top level of the infix to postfix converter
//
// usage:
//   i_in carries one ascii character per transfer with end_of_expression
//   set on the final character. o_out carries the postfix characters, with
//   last on the final one of an expression and overflow (valid with last)
//   set when an operator was dropped because the operator stack was full.
// sequencing:
//   a character is taken in the idle state and handled in the work state.
//   every operator popped by an incoming operator or by the flush at the
//   end of an expression takes a further pass through the single pop/emit
//   path of the operator stack. a result shows on o_out in the cycle after
//   it is produced.
// reset:
//   synchronous active-low i_rst_n empties the stack, clears the overflow
//   flag and drops any pending result. stack entries themselves are not
//   cleared; only entries below the count are ever read.
// back-pressure:
//   a single output register holds the pending result; while o_out.ready is
//   low, pushing operators are still taken; a character to emit waits
`default_nettype none
module infix_to_postfix_converter (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    itp_in_if.sink     i_in,
    itp_out_if.source  o_out
);

    itp_pkg::t_cmd  w_cmd;
    itp_pkg::t_stat w_stat;
    logic           w_in_ready;

    // sequencer: decides per cycle whether to take, emit, pop or push
    itp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    // stack, held character and output register
    itp_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_symbol       (i_in.symbol),
        .i_end          (i_in.end_of_expression),
        .i_out_ready    (o_out.ready),
        .o_stat         (w_stat),
        .o_out_valid    (o_out.valid),
        .o_out_symbol   (o_out.out_symbol),
        .o_out_last     (o_out.last),
        .o_out_overflow (o_out.overflow)
    );

    // input transfer only while the sequencer is idle
    assign i_in.ready = w_in_ready;

endmodule
`default_nettype wire

/* rtl/core/itp_ctrl.sv */
// sequencing state machine of the infix to postfix converter
`default_nettype none
module itp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire itp_pkg::t_stat i_stat,
    output itp_pkg::t_cmd      o_cmd,
    output logic               o_in_ready
);

    itp_pkg::t_state r_state;
    itp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            itp_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = itp_pkg::S_WORK;
                end
            end
            itp_pkg::S_WORK: begin
                if (!i_stat.is_op) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit_sym = 1'b1;
                        if (i_stat.is_end && i_stat.empty) begin
                            o_cmd.last      = 1'b1;
                            o_cmd.clear_ovf = 1'b1;
                            n_state         = itp_pkg::S_IDLE;
                        end else if (i_stat.is_end) begin
                            n_state = itp_pkg::S_FLUSH;
                        end else begin
                            n_state = itp_pkg::S_IDLE;
                        end
                    end
                end else if (i_stat.top_ge) begin
                    // pop operators of at least equal precedence
                    if (i_stat.out_free) begin
                        o_cmd.pop_emit = 1'b1;
                    end
                end else begin
                    if (i_stat.full) begin
                        o_cmd.set_ovf = 1'b1;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                    n_state = i_stat.is_end ? itp_pkg::S_FLUSH : itp_pkg::S_IDLE;
                end
            end
            itp_pkg::S_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.pop_emit = 1'b1;
                    if (i_stat.count_one) begin
                        o_cmd.last      = 1'b1;
                        o_cmd.clear_ovf = 1'b1;
                        n_state         = itp_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = itp_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/itp_dpath.sv */
// operator stack, item register and output register of the converter
`default_nettype none
module itp_dpath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire itp_pkg::t_cmd i_cmd,
    input  wire logic [7:0]    i_symbol,
    input  wire logic          i_end,
    input  wire logic          i_out_ready,
    output itp_pkg::t_stat     o_stat,
    output logic               o_out_valid,
    output logic [7:0]         o_out_symbol,
    output logic               o_out_last,
    output logic               o_out_overflow
);

    itp_pkg::t_opc              r_stack [itp_pkg::STACK_DEPTH];
    logic [itp_pkg::CNT_W-1:0]  r_count;
    logic                       r_ovf;
    logic [7:0]                 r_sym;
    logic                       r_end;
    itp_pkg::t_op               r_op;
    logic                       r_out_valid;
    logic [7:0]                 r_out_sym;
    logic                       r_out_last;
    logic                       r_out_ovf;

    logic [itp_pkg::CNT_W-1:0]  w_top_cnt;
    itp_pkg::t_opc              w_top;
    logic                       w_emit;
    logic [7:0]                 w_emit_sym;

    assign w_top_cnt = r_count - itp_pkg::CNT_W'(1);
    assign w_top     = r_stack[w_top_cnt[itp_pkg::IDX_W-1:0]];
    assign w_emit    = i_cmd.emit_sym | i_cmd.pop_emit;
    assign w_emit_sym = i_cmd.emit_sym ? r_sym : itp_pkg::op_char(w_top);

    always_comb begin
        o_stat.is_op     = r_op.is_op;
        o_stat.is_end    = r_end;
        // high precedence on the stack always pops, low only pops low
        o_stat.top_ge    = (r_count != '0) && (w_top[1] || !r_op.code[1]);
        o_stat.empty     = (r_count == '0);
        o_stat.full      = (r_count == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
        o_stat.count_one = (r_count == itp_pkg::CNT_W'(1));
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sym <= i_symbol;
            r_end <= i_end;
            r_op  <= itp_pkg::classify(i_symbol);
        end
        if (i_cmd.push) begin
            r_stack[r_count[itp_pkg::IDX_W-1:0]] <= r_op.code;
        end
        if (w_emit) begin
            r_out_sym  <= w_emit_sym;
            r_out_last <= i_cmd.last;
            r_out_ovf  <= i_cmd.last & r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_count <= r_count + itp_pkg::CNT_W'(1);
            end else if (i_cmd.pop_emit) begin
                r_count <= w_top_cnt;
            end
            if (i_cmd.clear_ovf) begin
                r_ovf <= 1'b0;
            end else if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_symbol   = r_out_sym;
    assign o_out_last     = r_out_last;
    assign o_out_overflow = r_out_ovf;

endmodule
`default_nettype wire

/* tb/tb.sv */
// self-checking testbench for the infix to postfix converter
`default_nettype none
module tb;
    import itp_pkg::*;

    typedef struct packed {
        logic [7:0] sym;
        logic       eoe;
    } char_item_t;

    typedef struct packed {
        logic [7:0] sym;
        logic       last;
        logic       ovf;
    } postfix_t;

    localparam int HALF_PERIOD  = 6;
    localparam int RANDOM_ITEMS = 310;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 90;
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_SHOWN    = 10;
    localparam logic [7:0] OPERATORS [4] = '{CHAR_ADD, CHAR_SUB, CHAR_MUL, CHAR_DIV};

    logic i_clk = 1'b0;
    logic i_rst_n;

    itp_in_if  in_ch ();
    itp_out_if out_ch ();

    infix_to_postfix_converter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // characters waiting to be offered; the head is the one on the bus
    char_item_t char_feed[$];
    // postfix characters the block still owes, oldest first
    postfix_t   postfix_due[$];

    // shadow operator stack, holding the operator characters themselves
    logic [7:0] held_ops [STACK_DEPTH];
    int         held_count  = 0;
    bit         drop_seen   = 1'b0;

    bit offer_live  = 1'b0;
    int accepted_in = 0;
    int total_items = 1;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int err_count   = 0;
    int shown       = 0;

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    function automatic bit is_operator(input logic [7:0] c);
        return (c == CHAR_ADD) || (c == CHAR_SUB) || (c == CHAR_MUL) || (c == CHAR_DIV);
    endfunction

    // multiply and divide bind tighter than add and subtract
    function automatic int op_rank(input logic [7:0] c);
        return (c == CHAR_MUL || c == CHAR_DIV) ? 3 : 2;
    endfunction

    function automatic logic [7:0] random_operand();
        logic [7:0] c;
        if ($urandom_range(99) < 75) begin
            c = 8'h61 + 8'($urandom_range(25));
        end else begin
            do c = 8'($urandom_range(255)); while (is_operator(c));
        end
        return c;
    endfunction

    task automatic queue_char(input logic [7:0] c, input logic eoe);
        char_item_t it;
        it.sym = c;
        it.eoe = eoe;
        char_feed.push_back(it);
    endtask

    // queues a whole expression, flagging its final character as the end
    task automatic queue_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) begin
            queue_char(s[k], k == s.len() - 1);
        end
    endtask

    // works out the postfix characters one accepted character gives rise to
    task automatic predict_postfix(input logic [7:0] sym, input logic eoe);
        postfix_t r;
        int       made;
        made  = 0;
        r.last = 1'b0;
        r.ovf  = 1'b0;
        if (!is_operator(sym)) begin
            r.sym = sym;
            postfix_due.push_back(r);
            made++;
        end else begin
            // pop everything of equal or higher rank; an empty stack never pops
            while (held_count > 0 && op_rank(held_ops[held_count - 1]) >= op_rank(sym)) begin
                held_count--;
                r.sym = held_ops[held_count];
                postfix_due.push_back(r);
                made++;
            end
            if (held_count < STACK_DEPTH) begin
                held_ops[held_count] = sym;
                held_count++;
            end else begin
                // full stack: operator is lost, remembered until the end
                drop_seen = 1'b1;
            end
        end
        if (eoe) begin
            while (held_count > 0) begin
                held_count--;
                r.sym = held_ops[held_count];
                postfix_due.push_back(r);
                made++;
            end
            if (made > 0) begin
                r      = postfix_due.pop_back();
                r.last = 1'b1;
                r.ovf  = drop_seen;
                postfix_due.push_back(r);
            end
            drop_seen = 1'b0;
        end
    endtask

    task automatic flag_error(input string msg);
        err_count++;
        if (shown < MAX_SHOWN) begin
            shown++;
            $display("tb: %0t %s", $time, msg);
        end
    endtask

    // input transfer: predict at the edge where the character is taken
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            predict_postfix(in_ch.symbol, in_ch.end_of_expression);
            void'(char_feed.pop_front());
            accepted_in++;
            offer_live = 1'b0;
        end
    end

    // sender: holds an offer until taken, otherwise offers the next or idles
    always @(negedge i_clk) begin
        int idle_pct;
        idle_pct = (accepted_in * 3 < total_items)     ? 26 :
                   (accepted_in * 3 < 2 * total_items) ? 62 : 0;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!offer_live) begin
            if (char_feed.size() > 0 && $urandom_range(99) >= idle_pct) begin
                in_ch.valid             <= 1'b1;
                in_ch.symbol            <= char_feed[0].sym;
                in_ch.end_of_expression <= char_feed[0].eoe;
                offer_live = 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // long hold-off of the receiver, counted in cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left = 0;
        end else if (hold_left > 0) begin
            hold_left--;
        end else if (!hold_done && accepted_in >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
    end

    // receiver: random stalls by phase, held off while the hold-off runs
    always @(negedge i_clk) begin
        int idle_pct;
        idle_pct = (accepted_in * 3 < total_items)     ? 62 :
                   (accepted_in * 3 < 2 * total_items) ? 26 : 0;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // output transfer: compare against the oldest owed character
    always @(posedge i_clk) begin
        postfix_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (postfix_due.size() == 0) begin
                flag_error($sformatf("unexpected result sym=%02h last=%b ovf=%b",
                    out_ch.out_symbol, out_ch.last, out_ch.overflow));
            end else begin
                want = postfix_due.pop_front();
                if (out_ch.out_symbol !== want.sym || out_ch.last !== want.last ||
                        out_ch.overflow !== want.ovf) begin
                    flag_error($sformatf(
                        "mismatch: expected sym=%02h last=%b ovf=%b, got sym=%02h last=%b ovf=%b",
                        want.sym, want.last, want.ovf,
                        out_ch.out_symbol, out_ch.last, out_ch.overflow));
                end
            end
        end
    end

    initial begin
        int n_ops;
        int k;
        in_ch.valid             = 1'b0;
        in_ch.symbol            = 8'h00;
        in_ch.end_of_expression = 1'b0;
        out_ch.ready            = 1'b0;
        i_rst_n                 = 1'b0;

        // directed: mixed ranks with pops on every operator kind
        queue_text("a+b*c-d/e");
        // byte extremes, ending on a plain character
        queue_char(8'h00, 1'b0);
        queue_char(8'hFF, 1'b1);
        // expression ending on an operator, which is pushed then flushed
        queue_text("x*y+");
        // parentheses pass straight through
        queue_text("(p)");
        // lone operator: empty stack compare, then flush of that operator alone
        queue_text("-");
        // equal rank pops, then a lower rank clearing the stack
        queue_text("*/-");
        // with only two ranks the stack never holds more than two, so the
        // dropped-push path cannot be reached and overflow must stay low

        // random: mostly well-formed expressions with random operands
        while (char_feed.size() < 21 + RANDOM_ITEMS) begin
            if ($urandom_range(99) < 80) begin
                n_ops = $urandom_range(6);
                for (k = 0; k <= n_ops; k++) begin
                    queue_char(random_operand(), k == n_ops);
                    if (k < n_ops) begin
                        queue_char(OPERATORS[$urandom_range(3)], 1'b0);
                    end
                end
            end else begin
                // noise: any byte, operators back to back, stray end flags
                repeat ($urandom_range(1, 6)) begin
                    queue_char(8'($urandom_range(255)), $urandom_range(7) == 0);
                end
            end
        end
        queue_char(8'h7A, 1'b1);
        total_items = char_feed.size();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (char_feed.size() > 0 || postfix_due.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
